### src/nlq_pkg.sv
package nlq_pkg;

  // Fixed field widths of the item formats.
  localparam int NET_ID_W   = 16;
  localparam int FLAGS_W    = 8;
  localparam int ADDR_W     = 8;
  localparam int RSSI_W     = 8;
  localparam int LIMIT_W    = 8;
  localparam int EXPIRY_W   = 16;
  localparam int QUAL_W     = 2;
  localparam int MAP_WORD_W = 64;

  // The emitted map always covers this many slots, split over two words.
  localparam int MAP_SLOTS  = 64;
  localparam int MAP_W      = QUAL_W * MAP_SLOTS;

  // Configuration port geometry: five 32-bit registers at 4-byte spacing.
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 5;

  typedef enum logic [2:0] {
    REG_NETWORK_ID   = 3'd0,
    REG_HELLO_MARKER = 3'd1,
    REG_STRONG_LIMIT = 3'd2,
    REG_MEDIUM_LIMIT = 3'd3,
    REG_EXPIRY_TICKS = 3'd4
  } reg_idx_t;

  localparam logic [NET_ID_W-1:0] RST_NETWORK_ID   = 16'hABCD;
  localparam logic [FLAGS_W-1:0]  RST_HELLO_MARKER = 8'hEE;
  localparam logic [LIMIT_W-1:0]  RST_STRONG_LIMIT = 8'h20;
  localparam logic [LIMIT_W-1:0]  RST_MEDIUM_LIMIT = 8'h30;
  localparam logic [EXPIRY_W-1:0] RST_EXPIRY_TICKS = 16'd3;

  localparam logic [QUAL_W-1:0] Q_NONE   = 2'b00;
  localparam logic [QUAL_W-1:0] Q_WEAK   = 2'b01;
  localparam logic [QUAL_W-1:0] Q_MEDIUM = 2'b10;
  localparam logic [QUAL_W-1:0] Q_STRONG = 2'b11;

  typedef struct packed {
    logic                      req_type;
    logic [NET_ID_W-1:0]       rx_network_id;
    logic [FLAGS_W-1:0]        rx_flags;
    logic [ADDR_W-1:0]         sender_address;
    logic signed [RSSI_W-1:0]  rssi;
  } in_item_t;

  typedef struct packed {
    logic [MAP_WORD_W-1:0] map_word;
    logic                  word_index;
    logic                  is_data;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic [NET_ID_W-1:0] network_id;
    logic [FLAGS_W-1:0]  hello_marker;
    logic [LIMIT_W-1:0]  strong_limit;
    logic [LIMIT_W-1:0]  medium_limit;
    logic [EXPIRY_W-1:0] expiry_ticks;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic tick_start;
    logic scan_en;
    logic hello_wr;
    logic emit_data;
    logic emit_word0;
    logic emit_word1;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic id_match;
    logic is_hello;
    logic scan_done;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_EMIT0,
    ST_EMIT1
  } state_t;

endpackage

### src/nlq_cfg.sv
module nlq_cfg
  import nlq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t            cfg_r;
  cfg_t            cfg_nxt;
  logic [2:0]      reg_idx;
  logic            wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_NETWORK_ID:   cfg_nxt.network_id   = pwdata[NET_ID_W-1:0];
        REG_HELLO_MARKER: cfg_nxt.hello_marker = pwdata[FLAGS_W-1:0];
        REG_STRONG_LIMIT: cfg_nxt.strong_limit = pwdata[LIMIT_W-1:0];
        REG_MEDIUM_LIMIT: cfg_nxt.medium_limit = pwdata[LIMIT_W-1:0];
        REG_EXPIRY_TICKS: cfg_nxt.expiry_ticks = pwdata[EXPIRY_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NETWORK_ID:   prdata = APB_DATA_W'(cfg_r.network_id);
      REG_HELLO_MARKER: prdata = APB_DATA_W'(cfg_r.hello_marker);
      REG_STRONG_LIMIT: prdata = APB_DATA_W'(cfg_r.strong_limit);
      REG_MEDIUM_LIMIT: prdata = APB_DATA_W'(cfg_r.medium_limit);
      REG_EXPIRY_TICKS: prdata = APB_DATA_W'(cfg_r.expiry_ticks);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.network_id   <= RST_NETWORK_ID;
      cfg_r.hello_marker <= RST_HELLO_MARKER;
      cfg_r.strong_limit <= RST_STRONG_LIMIT;
      cfg_r.medium_limit <= RST_MEDIUM_LIMIT;
      cfg_r.expiry_ticks <= RST_EXPIRY_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### src/nlq_ctrl.sv
module nlq_ctrl
  import nlq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.is_tick) begin
          cmd.tick_start = 1'b1;
          state_nxt      = ST_SCAN;
        end else if (!status.id_match) begin
          state_nxt = ST_IDLE;
        end else if (!status.is_hello) begin
          cmd.emit_data = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.hello_wr = 1'b1;
          state_nxt    = ST_EMIT0;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_EMIT0;
        end
      end
      ST_EMIT0: begin
        cmd.emit_word0 = 1'b1;
        state_nxt      = ST_EMIT1;
      end
      ST_EMIT1: begin
        cmd.emit_word1 = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### src/nlq_dpath.sv
module nlq_dpath
  import nlq_pkg::*;
#(
  parameter int ENTRIES   = 64,
  parameter int TIME_BITS = 16
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  cfg_t       cfg,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (TIME_BITS > EXPIRY_W) ? TIME_BITS : EXPIRY_W;
  localparam logic [CNT_W-1:0] ENTRY_CNT = CNT_W'(ENTRIES);

  in_item_t             in_r;
  logic [TIME_BITS-1:0] tick_r;
  logic [QUAL_W-1:0]    qual_r [ENTRIES];
  logic [TIME_BITS-1:0] ls_mem [ENTRIES];
  logic [ENTRIES-1:0]   ls_valid_r;
  logic [CNT_W-1:0]     rd_idx_r;
  logic                 chk_valid_r;
  logic [IDX_W-1:0]     chk_idx_r;
  logic [TIME_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic [LIMIT_W-1:0]   mag;
  logic [QUAL_W-1:0]    hello_q;
  logic                 addr_ok;
  logic                 rd_en;
  logic [TIME_BITS-1:0] ls_cur;
  logic [TIME_BITS-1:0] age;
  logic                 stale;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [QUAL_W-1:0]    wr_q;
  logic [MAP_W-1:0]     map_w;

  assign status.is_tick   = in_r.req_type;
  assign status.id_match  = (in_r.rx_network_id == cfg.network_id);
  assign status.is_hello  = (in_r.rx_flags == cfg.hello_marker);
  assign status.scan_done = (rd_idx_r == ENTRY_CNT);

  // Magnitude of the signed strength; the most negative code maps to 128.
  assign mag = in_r.rssi[RSSI_W-1] ? (LIMIT_W'(0) - LIMIT_W'(in_r.rssi))
                                   : LIMIT_W'(in_r.rssi);

  always_comb begin
    if (mag < cfg.strong_limit) begin
      hello_q = Q_STRONG;
    end else if (mag < cfg.medium_limit) begin
      hello_q = Q_MEDIUM;
    end else begin
      hello_q = Q_WEAK;
    end
  end

  assign addr_ok = (int'(in_r.sender_address) < ENTRIES);

  // Scan: read stage at rd_idx_r, age check in the following cycle at chk_idx_r.
  assign rd_en  = cmd.scan_en && (rd_idx_r < ENTRY_CNT);
  assign ls_cur = rd_vld_r ? rd_data_r : '0;
  assign age    = tick_r - ls_cur;
  assign stale  = chk_valid_r && (CMP_W'(age) > CMP_W'(cfg.expiry_ticks));

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = chk_idx_r;
    wr_q   = Q_NONE;
    if (cmd.hello_wr && addr_ok) begin
      wr_en  = 1'b1;
      wr_idx = in_r.sender_address[IDX_W-1:0];
      wr_q   = hello_q;
    end else if (stale) begin
      wr_en  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ls_mem[wr_idx] <= tick_r;
    end
    if (rd_en) begin
      rd_data_r <= ls_mem[rd_idx_r[IDX_W-1:0]];
      rd_vld_r  <= ls_valid_r[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
    chk_idx_r <= rd_idx_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qual_r      <= '{default: '0};
      ls_valid_r  <= '0;
      tick_r      <= '0;
      rd_idx_r    <= '0;
      chk_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        qual_r[wr_idx]     <= wr_q;
        ls_valid_r[wr_idx] <= 1'b1;
      end
      if (cmd.tick_start) begin
        tick_r      <= tick_r + TIME_BITS'(1);
        rd_idx_r    <= '0;
        chk_valid_r <= 1'b0;
      end else begin
        chk_valid_r <= rd_en;
        if (rd_en) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
      end
    end
  end

  for (genvar g = 0; g < MAP_SLOTS; g++) begin : g_map
    if (g < ENTRIES) begin : g_kept
      assign map_w[MAP_W-1-QUAL_W*g -: QUAL_W] = qual_r[g];
    end else begin : g_absent
      assign map_w[MAP_W-1-QUAL_W*g -: QUAL_W] = Q_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_data || cmd.emit_word0 || cmd.emit_word1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_data) begin
      out_item_r.map_word   <= '0;
      out_item_r.word_index <= 1'b0;
      out_item_r.is_data    <= 1'b1;
      out_item_r.last       <= 1'b1;
    end else if (cmd.emit_word0) begin
      out_item_r.map_word   <= map_w[MAP_W-1 -: MAP_WORD_W];
      out_item_r.word_index <= 1'b0;
      out_item_r.is_data    <= 1'b0;
      out_item_r.last       <= 1'b0;
    end else if (cmd.emit_word1) begin
      out_item_r.map_word   <= map_w[MAP_WORD_W-1:0];
      out_item_r.word_index <= 1'b1;
      out_item_r.is_data    <= 1'b0;
      out_item_r.last       <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### src/neighbor_link_quality_table.sv
// Channel   Handshake              Payload       Direction
// input     start / busy           in_item       in
// result    out_valid (strobe)     out_item      out
// config    psel/penable/pwrite    paddr/pwdata  in, prdata out
//
// An item is taken at a clock edge where start is high and busy is low.
// A scan report is decoded and then dropped, forwarded as data, or, if it is
// a hello, answered with the two map words; an expiry tick walks the
// last-seen memory through its single read port, one entry per cycle, and
// then emits the map. Results appear in the cycle after their command.
// Reset is synchronous and active low; quality flops and last-seen valid
// bits clear at once, so no clearing pass is needed.
// Results are strobed for one cycle each and cannot be held off.
module neighbor_link_quality_table
  import nlq_pkg::*;
#(
  parameter int ENTRIES   = 64,
  parameter int TIME_BITS = 16
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input item channel.
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  // Result channel.
  output logic                  out_valid,
  output out_item_t             out_item,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register bank: network id, hello marker, the two strength thresholds
  // and the expiry limit, all at 4-byte spacing.
  nlq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller takes an item, decodes it in the next cycle from the latched
  // copy, and then runs the scan for a tick and the map emission for a tick or a hello.
  nlq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // The datapath holds the quality flops, the last-seen memory with its
  // valid bits, the tick counter, the two-stage scan pipe and the output
  // register. The map is read straight from the quality flops.
  nlq_dpath #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // An accepted item always makes the block busy in the next cycle.
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // The first map word is always followed by the second one.
  a_word_pair : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.is_data && !out_item.word_index) |=>
    (out_valid && out_item.word_index && out_item.last))
    else $error("map word 0 not followed by word 1");

  // The second map word is always preceded by the first one.
  a_word_order : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.word_index) |->
    $past(out_valid && !out_item.word_index && !out_item.is_data))
    else $error("map word 1 without word 0");

  // A forwarded data packet is a single, empty, final result.
  a_data_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.is_data) |->
    (out_item.last && !out_item.word_index && (out_item.map_word == '0)))
    else $error("malformed data result");

endmodule

### tb/sv/tb.sv
module tb;
  import nlq_pkg::*;

  // The map always shows 64 slots, and the block is built with 64 entries.
  localparam int ENTRY_COUNT   = 64;
  localparam int ENTRY_IDX_W   = $clog2(ENTRY_COUNT);
  localparam int TIME_W        = 16;
  localparam int IN_ITEM_W     = $bits(in_item_t);
  // A tick walks every entry, so it keeps the block busy longest.
  // The idle wait after busy falls covers the output register stage.
  localparam int SETTLE_CYCLES = 8;
  // The slowest legal run is about 1100 items, each a tick followed by the
  // longest sender gap, so this limit leaves a wide margin.
  localparam int CYCLE_LIMIT   = 800000;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [PADDR_W-1:0]    paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  neighbor_link_quality_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the neighbor table, the tick counter and the registers.
  // It is advanced once per accepted item, in acceptance order.
  cfg_t              cfg_shadow;
  logic [QUAL_W-1:0] quality_shadow [ENTRY_COUNT];
  logic [TIME_W-1:0] seen_shadow [ENTRY_COUNT];
  logic [TIME_W-1:0] tick_shadow;

  // Output words the block still owes us, oldest first.
  out_item_t awaited_words [$];

  int errors          = 0;
  int words_checked   = 0;
  int hellos_sent     = 0;
  int data_sent       = 0;
  int ticks_sent      = 0;
  int foreign_sent    = 0;
  int settings_used   = 1;
  int sender_idle_pct = 0;
  int cycle_count     = 0;

  function automatic void clear_shadow();
    cfg_shadow.network_id   = RST_NETWORK_ID;
    cfg_shadow.hello_marker = RST_HELLO_MARKER;
    cfg_shadow.strong_limit = RST_STRONG_LIMIT;
    cfg_shadow.medium_limit = RST_MEDIUM_LIMIT;
    cfg_shadow.expiry_ticks = RST_EXPIRY_TICKS;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      quality_shadow[i] = Q_NONE;
      seen_shadow[i]    = '0;
    end
    tick_shadow = '0;
  endfunction

  // Queue the two map words. Entry 0 lands in bits 63:62 of word 0, and
  // entry 32 in the same bits of word 1.
  function automatic void queue_map_words();
    out_item_t word;
    for (int half = 0; half < 2; half++) begin
      word = '0;
      for (int slot = 0; slot < 32; slot++) begin
        word.map_word[MAP_WORD_W-1-2*slot -: QUAL_W] = quality_shadow[half*32 + slot];
      end
      word.word_index = half[0];
      word.is_data    = 1'b0;
      word.last       = (half == 1);
      awaited_words.push_back(word);
    end
  endfunction

  // Apply one accepted item to the shadow table and queue what it should emit.
  function automatic void update_neighbors(in_item_t it);
    logic [8:0]             magnitude;
    logic [TIME_W-1:0]      age;
    logic [QUAL_W-1:0]      grade;
    logic [ENTRY_IDX_W-1:0] slot_idx;
    out_item_t              data_word;
    if (it.req_type) begin
      // The tick advances time, and then every entry whose age has passed
      // the expiry limit is dropped and restamped with the new time.
      ticks_sent++;
      tick_shadow = tick_shadow + 1'b1;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        age = tick_shadow - seen_shadow[i];
        if (age > cfg_shadow.expiry_ticks) begin
          quality_shadow[i] = Q_NONE;
          seen_shadow[i]    = tick_shadow;
        end
      end
      queue_map_words();
    end else if (it.rx_network_id != cfg_shadow.network_id) begin
      // A packet from another network is dropped without any output.
      foreign_sent++;
    end else if (it.rx_flags != cfg_shadow.hello_marker) begin
      data_sent++;
      data_word         = '0;
      data_word.is_data = 1'b1;
      data_word.last    = 1'b1;
      awaited_words.push_back(data_word);
    end else begin
      // A hello grades the sender by |rssi|, where -128 counts as 128. Senders
      // outside the table change nothing, but the map is still emitted.
      hellos_sent++;
      magnitude = it.rssi[RSSI_W-1] ? (9'd256 - {1'b0, it.rssi}) : {1'b0, it.rssi};
      if (magnitude < {1'b0, cfg_shadow.strong_limit}) grade = Q_STRONG;
      else if (magnitude < {1'b0, cfg_shadow.medium_limit}) grade = Q_MEDIUM;
      else grade = Q_WEAK;
      if (it.sender_address < ENTRY_COUNT) begin
        slot_idx                 = it.sender_address[ENTRY_IDX_W-1:0];
        quality_shadow[slot_idx] = grade;
        seen_shadow[slot_idx]    = tick_shadow;
      end
      queue_map_words();
    end
  endfunction

  // Compare each strobed output word with the oldest one still owed.
  always @(posedge clk) begin : check_words
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (awaited_words.size() == 0) begin
        $error("unexpected output word: map_word %h word_index %b is_data %b last %b",
               out_item.map_word, out_item.word_index, out_item.is_data, out_item.last);
        errors++;
      end else begin
        want = awaited_words.pop_front();
        words_checked++;
        if (out_item.map_word !== want.map_word) begin
          $error("map_word: expected %h, got %h", want.map_word, out_item.map_word);
          errors++;
        end
        if (out_item.word_index !== want.word_index) begin
          $error("word_index: expected %b, got %b", want.word_index, out_item.word_index);
          errors++;
        end
        if (out_item.is_data !== want.is_data) begin
          $error("is_data: expected %b, got %b", want.is_data, out_item.is_data);
          errors++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_item.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d output words still owed",
               cycle_count, awaited_words.size());
      $display("** neighbor_link_quality_table: FAILED **");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it. If the sender does
  // not idle, start stays high so that the next item follows back to back.
  task automatic send_item(in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    update_neighbors(it);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      // Mostly short gaps, with some long enough to end anywhere in a tick walk.
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(5, 75)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Wait until every owed word has arrived and the block is idle again.
  // A dropped packet owes nothing, so the extra idle wait covers that case.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, update the shadow copy, then read the register back.
  task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] mask;
    case (idx)
      REG_NETWORK_ID:   mask = 32'h0000_FFFF;
      REG_EXPIRY_TICKS: mask = 32'h0000_FFFF;
      default:          mask = 32'h0000_00FF;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value & mask;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_NETWORK_ID:   cfg_shadow.network_id   = value[NET_ID_W-1:0];
      REG_HELLO_MARKER: cfg_shadow.hello_marker = value[FLAGS_W-1:0];
      REG_STRONG_LIMIT: cfg_shadow.strong_limit = value[LIMIT_W-1:0];
      REG_MEDIUM_LIMIT: cfg_shadow.medium_limit = value[LIMIT_W-1:0];
      REG_EXPIRY_TICKS: cfg_shadow.expiry_ticks = value[EXPIRY_W-1:0];
      default: ;
    endcase
    // Read back at the same address. psel stays high into the new setup cycle.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if ((prdata & mask) !== (value & mask)) begin
      $error("register %s readback: expected %h, got %h", idx.name(), value & mask,
             prdata & mask);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(logic [15:0] net_id, logic [7:0] marker, logic [7:0] strong_lim,
                              logic [7:0] medium_lim, logic [15:0] expiry);
    write_reg(REG_NETWORK_ID, {16'h0, net_id});
    write_reg(REG_HELLO_MARKER, {24'h0, marker});
    write_reg(REG_STRONG_LIMIT, {24'h0, strong_lim});
    write_reg(REG_MEDIUM_LIMIT, {24'h0, medium_lim});
    write_reg(REG_EXPIRY_TICKS, {16'h0, expiry});
    settings_used++;
  endtask

  function automatic in_item_t scan_report(logic [15:0] net_id, logic [7:0] flags,
                                           logic [7:0] addr, logic [7:0] strength);
    in_item_t it;
    it.req_type       = 1'b0;
    it.rx_network_id  = net_id;
    it.rx_flags       = flags;
    it.sender_address = addr;
    it.rssi           = strength;
    return it;
  endfunction

  // A tick carries random junk in its other fields, which the block must ignore.
  function automatic in_item_t expiry_tick();
    in_item_t it;
    it          = in_item_t'(IN_ITEM_W'({$urandom, $urandom}));
    it.req_type = 1'b1;
    return it;
  endfunction

  function automatic in_item_t hello_from(logic [7:0] addr, logic [7:0] strength);
    return scan_report(cfg_shadow.network_id, cfg_shadow.hello_marker, addr, strength);
  endfunction

  // Most random items are well-formed hellos and data reports on our own
  // network, so the table fills up and ages out. Ticks and packets from other
  // networks are mixed in.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it   = in_item_t'(IN_ITEM_W'({$urandom, $urandom}));
    pick = $urandom_range(0, 99);
    it.req_type = (pick < 18);
    if (pick >= 18 && pick < 28) begin
      if (it.rx_network_id == cfg_shadow.network_id) it.rx_network_id[0] = ~it.rx_network_id[0];
    end else if (pick >= 28) begin
      it.rx_network_id = cfg_shadow.network_id;
      if (pick < 43) begin
        if (it.rx_flags == cfg_shadow.hello_marker) it.rx_flags[0] = ~it.rx_flags[0];
      end else begin
        it.rx_flags = cfg_shadow.hello_marker;
        if ($urandom_range(0, 4) != 0) begin
          it.sender_address = 8'($urandom_range(0, ENTRY_COUNT - 1));
        end
      end
    end
    return it;
  endfunction

  task automatic run_traffic(int count, int idle_pct);
    sender_idle_pct = idle_pct;
    repeat (count) send_item(random_item());
    settle();
  endtask

  // Right after reset every quality reads zero, and one tick ages nothing out.
  task automatic test_map_after_reset();
    send_item(expiry_tick());
  endtask

  // Cover each rssi band at its edges under the reset limits of 32 and 48,
  // including -128, which counts as a magnitude of 128.
  task automatic test_rssi_bands();
    send_item(hello_from(8'd0, 8'sd0));
    send_item(hello_from(8'd1, 8'sd31));
    send_item(hello_from(8'd2, -8'sd32));
    send_item(hello_from(8'd3, 8'sd47));
    send_item(hello_from(8'd4, 8'sd48));
    send_item(hello_from(8'd5, 8'sd127));
    send_item(hello_from(8'd62, 8'h80));
    send_item(hello_from(8'd63, -8'sd1));
  endtask

  // A sender outside the table still gets a map, but the map stays unchanged.
  task automatic test_address_range();
    send_item(hello_from(8'd64, 8'sd0));
    send_item(hello_from(8'd128, -8'sd20));
    send_item(hello_from(8'd255, 8'sd10));
  endtask

  // Flags that are not a hello come out as a data word. A foreign network id
  // gives no output, even when the flags byte looks like a hello.
  task automatic test_data_and_foreign();
    send_item(scan_report(cfg_shadow.network_id, 8'h00, 8'd7, 8'sd5));
    send_item(scan_report(cfg_shadow.network_id, 8'hFF, 8'd255, 8'h80));
    send_item(scan_report(cfg_shadow.network_id, cfg_shadow.hello_marker ^ 8'h01, 8'd9, 8'sd0));
    send_item(scan_report(cfg_shadow.network_id ^ 16'h0001, cfg_shadow.hello_marker, 8'd1,
                          8'sd0));
    send_item(scan_report(16'h0000, cfg_shadow.hello_marker, 8'd2, 8'sd0));
    send_item(scan_report(16'hFFFF, 8'hFF, 8'd3, 8'sd127));
  endtask

  // With the limit at 3, entries seen at tick 1 survive ticks 2 to 4 and are
  // dropped on tick 5. A neighbor first heard in between, at tick 3, must survive.
  task automatic test_expiry();
    send_item(expiry_tick());
    send_item(expiry_tick());
    send_item(hello_from(8'd40, -8'sd40));
    send_item(expiry_tick());
    send_item(expiry_tick());
  endtask

  task automatic test_traffic_mid_config();
    apply_config(16'($urandom_range(1, 16'hFFFE)), 8'($urandom_range(1, 254)), 8'd20, 8'd60,
                 16'd5);
    run_traffic(350, 27);
  endtask

  // With both limits at 0 every hello is weak, and with expiry 0 every tick
  // clears every entry.
  task automatic test_traffic_low_extremes();
    apply_config(16'h0000, 8'h00, 8'd0, 8'd0, 16'd0);
    run_traffic(350, 72);
  endtask

  // With both limits at 128 only -128 is weak, and entries never expire.
  task automatic test_traffic_high_extremes();
    apply_config(16'hFFFF, 8'hFF, 8'd128, 8'd128, 16'hFFFF);
    run_traffic(200, 0);
  endtask

  // A strong limit above the medium limit leaves no medium band at all.
  task automatic test_traffic_inverted_limits();
    apply_config(16'h5A3C, 8'h81, 8'd64, 8'd16, 16'd2);
    run_traffic(200, 0);
  endtask

  initial begin
    clear_shadow();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_pct = 27;
    test_map_after_reset();
    test_rssi_bands();
    test_address_range();
    test_data_and_foreign();
    test_expiry();
    settle();
    test_traffic_mid_config();
    test_traffic_low_extremes();
    test_traffic_high_extremes();
    test_traffic_inverted_limits();
    $display("checked %0d output words from %0d hellos, %0d data reports and %0d ticks",
             words_checked, hellos_sent, data_sent, ticks_sent);
    $display("%0d foreign packets dropped, %0d register settings applied",
             foreign_sent, settings_used);
    if (errors == 0) begin
      $display("** neighbor_link_quality_table: PASSED **");
    end else begin
      $display("** neighbor_link_quality_table: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
src/nlq_pkg.sv
src/nlq_cfg.sv
src/nlq_ctrl.sv
src/nlq_dpath.sv
src/neighbor_link_quality_table.sv
tb/sv/tb.sv
